// File: rtl/assert_macros.svh
// assertion macros for the checker file hta_checker.sv
// no dependencies; every macro is clocked and held off during reset
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// expression must hold at every clock edge out of reset
`define HTA_ASSERT_ALWAYS(lbl, ck, rstn, expr) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (expr)) \
		else $error("assertion failed");

// same-cycle implication
`define HTA_ASSERT_IMPL(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |-> (cons)) \
		else $error("assertion failed");

// next-cycle implication
`define HTA_ASSERT_NEXT(lbl, ck, rstn, ante, cons) \
	lbl: assert property (@(posedge ck) disable iff (!(rstn)) (ante) |=> (cons)) \
		else $error("assertion failed");

`endif

// File: rtl/hta_pkg.sv
// shared types and constants of the handle table allocator
// no dependencies
package hta_pkg;

	localparam int HANDLES   = 256;
	localparam int RESERVED  = 4;
	localparam int SIZE_BITS = 32;

	localparam int IDX_W = $clog2(HANDLES);
	localparam int CNT_W = $clog2(HANDLES + 1);
	// wide enough to compare any handle or index against the table bounds
	localparam int CMP_W = 17;
	localparam bit NO_ORDINARY = (RESERVED >= HANDLES);

	localparam logic [1:0] OP_INSERT = 2'd0;
	localparam logic [1:0] OP_ALLOC  = 2'd1;
	localparam logic [1:0] OP_FREE   = 2'd2;
	localparam logic [1:0] OP_QUERY  = 2'd3;

	localparam logic [1:0] ST_OK   = 2'd0;
	localparam logic [1:0] ST_BAD  = 2'd1;
	localparam logic [1:0] ST_FULL = 2'd2;

	typedef struct packed {
		logic [1:0]  op;
		logic [7:0]  handle;
		logic [31:0] size;
	} req_t;

	typedef struct packed {
		logic [7:0]  result_handle;
		logic [31:0] result_size;
		logic [1:0]  status;
	} rsp_t;

	typedef struct packed {
		logic             set;
		logic             clr;
		logic [IDX_W-1:0] idx;
	} mark_cmd_t;

endpackage

// File: rtl/hta_marks.sv
// used marks of the handle table, one flop per handle, cleared at reset
// depends on hta_pkg
module hta_marks (
	input  logic               clk,
	input  logic               arst_n,
	input  hta_pkg::mark_cmd_t cmd,
	input  logic [hta_pkg::IDX_W-1:0] look_idx,
	output logic               used
);
	import hta_pkg::*;

	logic [HANDLES-1:0] used_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			used_q <= '0;
		end else if (cmd.set) begin
			used_q[cmd.idx] <= 1'b1;
		end else if (cmd.clr) begin
			used_q[cmd.idx] <= 1'b0;
		end
	end

	assign used = used_q[look_idx];

endmodule

// File: rtl/handle_table_allocator_unit.sv
// handle table allocator: next-fit handle allocation over a table of sizes
// depends on hta_pkg and hta_marks
// steps from accept to rsp_valid: insert and rejected or unused-handle requests
// go through S_RESP only; free of a used ordinary handle or query of a used
// handle go through S_READ and S_RESP; allocate walks 1 to HANDLES-RESERVED
// marks in S_SCAN before S_RESP, and S_RESP waits while a stalled result is held.
// one item at a time: the next item is taken only back in S_IDLE with no stalled result
// reset clears all used marks at once; sizes are undefined until written.
module handle_table_allocator_unit (
	input  logic          clk,
	input  logic          arst_n,
	input  hta_pkg::req_t req,
	input  logic          req_valid,
	output logic          req_stall,
	output hta_pkg::rsp_t rsp,
	output logic          rsp_valid,
	input  logic          rsp_stall
);
	import hta_pkg::*;

	typedef enum logic [3:0] {
		S_IDLE = 4'b0001,
		S_SCAN = 4'b0010,
		S_READ = 4'b0100,
		S_RESP = 4'b1000
	} state_t;

	state_t                 state_q;
	logic [SIZE_BITS-1:0]   size_q;
	logic [IDX_W-1:0]       idx_q;
	logic [CNT_W-1:0]       cnt_q;
	logic [IDX_W-1:0]       next_try_q;
	rsp_t                   res_q;
	rsp_t                   rsp_q;
	logic                   rsp_valid_q;

	logic [SIZE_BITS-1:0]   mem [HANDLES];
	logic [SIZE_BITS-1:0]   rdata_q;

	logic                   accept;
	logic                   out_free;
	logic [IDX_W-1:0]       req_idx;
	logic [SIZE_BITS-1:0]   req_size;
	logic                   in_table;
	logic                   in_reserved;
	logic                   used;
	mark_cmd_t              mark_cmd;
	logic [IDX_W-1:0]       look_idx;
	logic                   we;
	logic [IDX_W-1:0]       waddr;
	logic [SIZE_BITS-1:0]   wdata;
	logic [IDX_W-1:0]       start_idx;
	logic                   insert_ok;

	assign out_free    = !rsp_valid_q || !rsp_stall;
	assign req_stall   = (state_q != S_IDLE) || (rsp_valid_q && rsp_stall);
	assign accept      = req_valid && !req_stall;
	assign req_idx     = IDX_W'(req.handle);
	assign req_size    = SIZE_BITS'(req.size);
	assign in_table    = CMP_W'(req.handle) < CMP_W'(HANDLES);
	assign in_reserved = CMP_W'(req.handle) < CMP_W'(RESERVED);
	assign look_idx    = (state_q == S_IDLE) ? req_idx : idx_q;
	assign insert_ok   = (req.handle != 8'd0) && in_reserved && in_table && !used;

	// a stray pointer restarts the walk at the first ordinary handle
	assign start_idx = ((CMP_W'(next_try_q) < CMP_W'(RESERVED)) ||
		(CMP_W'(next_try_q) >= CMP_W'(HANDLES))) ? IDX_W'(RESERVED) : next_try_q;

	hta_marks u_marks (
		.clk      (clk),
		.arst_n   (arst_n),
		.cmd      (mark_cmd),
		.look_idx (look_idx),
		.used     (used)
	);

	always_comb begin
		mark_cmd = '{set: 1'b0, clr: 1'b0, idx: look_idx};
		we       = 1'b0;
		waddr    = look_idx;
		wdata    = size_q;
		case (state_q)
			S_IDLE: begin
				if (accept && req.op == OP_INSERT && insert_ok) begin
					mark_cmd.set = 1'b1;
					we           = 1'b1;
					wdata        = req_size;
				end
				if (accept && req.op == OP_FREE && !in_reserved && in_table && used) begin
					mark_cmd.clr = 1'b1;
				end
			end
			S_SCAN: begin
				if (!used) begin
					mark_cmd.set = 1'b1;
					we           = 1'b1;
				end
			end
			default: ;
		endcase
	end

	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
		rdata_q <= mem[req_idx];
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q     <= S_IDLE;
			next_try_q  <= IDX_W'(RESERVED);
			rsp_valid_q <= 1'b0;
			idx_q       <= '0;
			cnt_q       <= '0;
			res_q       <= '0;
		end else begin
			if (state_q == S_RESP && out_free) begin
				rsp_valid_q <= 1'b1;
			end else if (rsp_valid_q && !rsp_stall) begin
				rsp_valid_q <= 1'b0;
			end
			case (state_q)
				S_IDLE: begin
					if (accept) begin
						state_q <= S_RESP;
						idx_q   <= start_idx;
						cnt_q   <= CNT_W'(HANDLES - RESERVED);
						case (req.op)
							OP_INSERT: begin
								if (insert_ok) begin
									res_q <= '{req.handle, 32'(req_size), ST_OK};
								end else begin
									res_q <= '{req.handle, 32'd0, ST_BAD};
								end
							end
							OP_ALLOC: begin
								if (NO_ORDINARY) begin
									res_q <= '{8'd0, 32'd0, ST_FULL};
								end else begin
									state_q <= S_SCAN;
								end
							end
							OP_FREE: begin
								if (in_reserved) begin
									res_q <= '{req.handle, 32'd0,
										(req.handle != 8'd0) ? ST_OK : ST_BAD};
								end else if (!in_table || !used) begin
									res_q <= '{req.handle, 32'd0, ST_BAD};
								end else begin
									res_q   <= '{req.handle, 32'd0, ST_OK};
									state_q <= S_READ;
								end
							end
							default: begin
								res_q <= '{req.handle, 32'd0, ST_OK};
								if (in_table && used) begin
									state_q <= S_READ;
								end
							end
						endcase
					end
				end
				S_SCAN: begin
					if (!used) begin
						next_try_q <= idx_q;
						res_q      <= '{8'(idx_q), 32'(size_q), ST_OK};
						state_q    <= S_RESP;
					end else if (cnt_q == CNT_W'(1)) begin
						res_q   <= '{8'd0, 32'd0, ST_FULL};
						state_q <= S_RESP;
					end else begin
						idx_q <= (idx_q == IDX_W'(HANDLES - 1)) ? IDX_W'(RESERVED)
							: idx_q + IDX_W'(1);
						cnt_q <= cnt_q - CNT_W'(1);
					end
				end
				S_READ: begin
					res_q.result_size <= 32'(rdata_q);
					state_q           <= S_RESP;
				end
				S_RESP: begin
					if (out_free) begin
						state_q <= S_IDLE;
					end
				end
				default: state_q <= S_IDLE;
			endcase
		end
	end

	// payload registers, no reset needed
	always_ff @(posedge clk) begin
		if (state_q == S_IDLE && accept) begin
			size_q <= req_size;
		end
		if (state_q == S_RESP && out_free) begin
			rsp_q <= res_q;
		end
	end

	assign rsp       = rsp_q;
	assign rsp_valid = rsp_valid_q;

endmodule

// File: rtl/hta_checker.sv
// port-level checks of the handle table allocator, bound to the top level
// depends on hta_pkg and assert_macros.svh
`include "assert_macros.svh"

module hta_checker (
	input logic          clk,
	input logic          arst_n,
	input hta_pkg::req_t req,
	input logic          req_valid,
	input logic          req_stall,
	input hta_pkg::rsp_t rsp,
	input logic          rsp_valid,
	input logic          rsp_stall
);
	import hta_pkg::*;

	// one item in flight: an accepted item blocks the next one
	`HTA_ASSERT_NEXT(a_one_in_flight, clk, arst_n, req_valid && !req_stall, req_stall)

	// a waiting result holds back new items
	`HTA_ASSERT_IMPL(a_hold_input, clk, arst_n, rsp_valid && rsp_stall, req_stall)

	// a full table gives no handle and no size
	`HTA_ASSERT_IMPL(a_full_empty, clk, arst_n, rsp_valid && rsp.status == ST_FULL, rsp.result_handle == 8'd0 && rsp.result_size == 32'd0)

	// stalled result stays put
	`HTA_ASSERT_NEXT(a_rsp_hold, clk, arst_n, rsp_valid && rsp_stall, rsp_valid && $stable(rsp))

endmodule

bind handle_table_allocator_unit hta_checker u_hta_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.req       (req),
	.req_valid (req_valid),
	.req_stall (req_stall),
	.rsp       (rsp),
	.rsp_valid (rsp_valid),
	.rsp_stall (rsp_stall)
);
